FILE: src/pic_pkg.sv
// Shared types, sizes and codes of the convex polygon point tester.
package pic_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VA_W         = $clog2(MAX_VERTICES);
	localparam int CNT_W        = VA_W + 1;
	localparam int Q_DEPTH      = 2;
	localparam int QA_W         = $clog2(Q_DEPTH);
	localparam int CFG_IDX_W    = 3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE   = 3'd5;

	typedef enum logic [1:0] {
		KIND_VERT  = 2'd0,
		KIND_LAST  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} vertex_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} pic_entry_t;

endpackage

FILE: src/pic_ifs.sv
// Handshake channel interfaces: input items, results and configuration writes.
interface pic_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic               last_vertex;
	modport source (output valid, output opcode, output coord_x, output coord_y,
		output last_vertex, input ready);
	modport sink (input valid, input opcode, input coord_x, input coord_y,
		input last_vertex, output ready);
endinterface

interface pic_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic status;
	modport source (output valid, output inside_res, output status, input ready);
	modport sink (input valid, input inside_res, input status, output ready);
endinterface

interface pic_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/pic_front.sv
// Front end: accepts input items and classifies them for the work queue.
module pic_front import pic_pkg::*; (
	pic_in_if.sink     item,
	output logic       push_valid,
	output pic_entry_t push_entry,
	input  logic       push_ready
);

	// classify: query, plain vertex or closing vertex
	always_comb begin
		push_entry.x = item.coord_x;
		push_entry.y = item.coord_y;
		if (item.opcode == OP_QUERY) begin
			push_entry.kind = KIND_QUERY;
		end else if (item.last_vertex) begin
			push_entry.kind = KIND_LAST;
		end else begin
			push_entry.kind = KIND_VERT;
		end
	end

	assign push_valid = item.valid;
	assign item.ready = push_ready;

endmodule

FILE: src/pic_queue.sv
// Short FIFO of classified items between the front end and the executor.
module pic_queue import pic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  pic_entry_t push_entry,
	output logic       push_ready,
	output logic       pop_valid,
	output pic_entry_t pop_entry,
	input  logic       pop_ready
);

	pic_entry_t            slot_q [Q_DEPTH];
	logic [QA_W-1:0]       wr_ptr_q;
	logic [QA_W-1:0]       rd_ptr_q;
	logic [QA_W:0]         fill_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (fill_q != (QA_W+1)'(Q_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// store pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(Q_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(Q_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/pic_back.sv
// Executor: vertex store, chain build, query transform, chain search and result register.
module pic_back import pic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pic_cfg_if.sink    cfg,
	input  logic       q_valid,
	input  pic_entry_t q_entry,
	output logic       q_ready,
	pic_out_if.source  result
);

	typedef enum logic [23:0] {
		ST_IDLE   = 24'h000001,
		ST_FIND_R = 24'h000002,
		ST_FIND_U = 24'h000004,
		ST_TOP_R  = 24'h000008,
		ST_TOP_U  = 24'h000010,
		ST_UP_I   = 24'h000020,
		ST_UP_W   = 24'h000040,
		ST_UP_U   = 24'h000080,
		ST_LOW_W  = 24'h000100,
		ST_LOW_U  = 24'h000200,
		ST_XF     = 24'h000400,
		ST_CHK    = 24'h000800,
		ST_SA     = 24'h001000,
		ST_SB     = 24'h002000,
		ST_SC     = 24'h004000,
		ST_F1     = 24'h008000,
		ST_F2     = 24'h010000,
		ST_F3     = 24'h020000,
		ST_F4     = 24'h040000,
		ST_M1     = 24'h080000,
		ST_M2     = 24'h100000,
		ST_M3     = 24'h200000,
		ST_RES    = 24'h400000,
		ST_SPARE  = 24'h800000
	} state_t;

	localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
	localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

	// configuration registers
	logic signed [31:0] origin_x_q, origin_y_q;
	logic [31:0]        inv_x_q, inv_y_q;
	logic signed [17:0] cos_q, sin_q;

	// control state
	state_t             state_q;
	logic [CNT_W-1:0]   count_q, ulen_q, llen_q, i_q, steps_q, lo_q, hi_q;
	logic               load_open_q, ready_q, sel_q;
	logic [2:0]         step_q;
	logic               ov_q;

	// payload registers
	logic [VA_W-1:0]    best_q, top_q, idx_q;
	logic signed [31:0] bx_q, by_q, topy_q, curx_q, cury_q;
	logic signed [31:0] tbx_q, tby_q, bby_q;
	logic signed [32:0] dx_q, dy_q;
	logic [31:0]        magx_q, magy_q;
	logic               negx_q, negy_q;
	logic signed [65:0] prod_q, acc_q, p1_q;
	logic signed [31:0] sx_q, sy_q, tx_q, ty_q, lx_q, ly_q;
	logic signed [32:0] da_q, db_q, dc_q, dd_q;
	logic               res_in_q, res_st_q, out_in_q, out_st_q;

	// memories
	vertex_t            vmem [MAX_VERTICES];
	logic [VA_W-1:0]    up_mem [MAX_VERTICES];
	logic [VA_W-1:0]    low_mem [MAX_VERTICES];
	vertex_t            v_rd_q;
	logic [VA_W-1:0]    up_rd_q, low_rd_q;

	// combinational helpers
	logic               pop;
	logic [CNT_W-1:0]   cnt_eff, cnt_new, curlen, len_m1, klamp;
	logic [CNT_W:0]     mid_sum;
	logic [CNT_W-1:0]   mid;
	logic               v_we, up_we, low_we, take, out_free;
	logic [VA_W-1:0]    v_addr, c_addr, chain_d, last_idx;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	function automatic logic signed [31:0] scale_fin(input logic [65:0] p, input logic neg);
		logic [47:0] m;
		m = p[63:16];
		if (neg) begin
			scale_fin = (m > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(~m[31:0] + 32'd1);
		end else begin
			scale_fin = (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end
	endfunction

	function automatic logic signed [31:0] sat_shr(input logic signed [65:0] a);
		logic signed [65:0] sh;
		sh = a >>> 16;
		if (sh > SAT_MAX) begin
			sat_shr = 32'h7FFF_FFFF;
		end else if (sh < SAT_MIN) begin
			sat_shr = 32'h8000_0000;
		end else begin
			sat_shr = sh[31:0];
		end
	endfunction

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign q_ready  = (state_q == ST_IDLE);
	assign cnt_eff  = load_open_q ? count_q : '0;
	assign v_we     = pop && (q_entry.kind != KIND_QUERY) && (cnt_eff < CNT_W'(MAX_VERTICES));
	assign cnt_new  = v_we ? cnt_eff + 1'b1 : cnt_eff;
	assign last_idx = VA_W'(count_q - 1'b1);
	assign up_we    = (state_q == ST_UP_W);
	assign low_we   = (state_q == ST_LOW_W);
	assign chain_d  = sel_q ? low_rd_q : up_rd_q;
	assign curlen   = sel_q ? llen_q : ulen_q;
	assign len_m1   = curlen - 1'b1;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CNT_W:1];
	assign out_free = !ov_q || result.ready;
	assign take     = (i_q == '0) || (v_rd_q.x < bx_q) || ((v_rd_q.x == bx_q) && (v_rd_q.y < by_q));

	// clamp the found edge index into the chain
	always_comb begin
		if (lo_q < CNT_W'(1)) begin
			klamp = CNT_W'(1);
		end else if (lo_q > len_m1) begin
			klamp = len_m1;
		end else begin
			klamp = lo_q;
		end
	end

	// memory read addresses
	always_comb begin
		v_addr = '0;
		c_addr = '0;
		case (state_q)
			ST_FIND_R: v_addr = i_q[VA_W-1:0];
			ST_TOP_R:  v_addr = (top_q == '0) ? last_idx : top_q - 1'b1;
			ST_UP_W:   v_addr = (idx_q == '0) ? last_idx : idx_q - 1'b1;
			ST_LOW_W:  v_addr = (idx_q == last_idx) ? '0 : idx_q + 1'b1;
			ST_SA:     c_addr = mid[VA_W-1:0];
			ST_SB:     v_addr = chain_d;
			ST_F1:     c_addr = VA_W'(klamp - 1'b1);
			ST_F2: begin
				v_addr = chain_d;
				c_addr = klamp[VA_W-1:0];
			end
			ST_F3:     v_addr = chain_d;
			default: begin
				v_addr = '0;
				c_addr = '0;
			end
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_XF) begin
			case (step_q)
				3'd1: begin
					mul_a = {1'b0, magx_q};
					mul_b = {1'b0, inv_x_q};
				end
				3'd2: begin
					mul_a = {1'b0, magy_q};
					mul_b = {1'b0, inv_y_q};
				end
				3'd3: begin
					mul_a = {sx_q[31], sx_q};
					mul_b = {{15{cos_q[17]}}, cos_q};
				end
				3'd4: begin
					mul_a = {sy_q[31], sy_q};
					mul_b = {{15{sin_q[17]}}, sin_q};
				end
				3'd5: begin
					mul_a = {sy_q[31], sy_q};
					mul_b = {{15{cos_q[17]}}, cos_q};
				end
				3'd6: begin
					mul_a = {sx_q[31], sx_q};
					mul_b = {{15{sin_q[17]}}, sin_q};
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (state_q == ST_M1) begin
			mul_a = da_q;
			mul_b = db_q;
		end else if (state_q == ST_M2) begin
			mul_a = dc_q;
			mul_b = dd_q;
		end
	end

	assign mul_p = mul_a * mul_b;

	// vertex store
	always_ff @(posedge clk) begin
		if (v_we) begin
			vmem[cnt_eff[VA_W-1:0]] <= '{x: q_entry.x, y: q_entry.y};
		end
		v_rd_q <= vmem[v_addr];
	end

	// upper chain store
	always_ff @(posedge clk) begin
		if (up_we) begin
			up_mem[ulen_q[VA_W-1:0]] <= idx_q;
		end
		up_rd_q <= up_mem[c_addr];
	end

	// lower chain store
	always_ff @(posedge clk) begin
		if (low_we) begin
			low_mem[llen_q[VA_W-1:0]] <= idx_q;
		end
		low_rd_q <= low_mem[c_addr];
	end

	assign cfg.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			inv_x_q    <= 32'd65536;
			inv_y_q    <= 32'd65536;
			cos_q      <= 18'sd65536;
			sin_q      <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ORIGIN_X:    origin_x_q <= cfg.data;
				CFG_ORIGIN_Y:    origin_y_q <= cfg.data;
				CFG_INV_SCALE_X: inv_x_q    <= cfg.data;
				CFG_INV_SCALE_Y: inv_y_q    <= cfg.data;
				CFG_COS_ANGLE:   cos_q      <= cfg.data[17:0];
				CFG_SIN_ANGLE:   sin_q      <= cfg.data[17:0];
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				dx_q <= {q_entry.x[31], q_entry.x} - {origin_x_q[31], origin_x_q};
				dy_q <= {q_entry.y[31], q_entry.y} - {origin_y_q[31], origin_y_q};
			end
			ST_FIND_U: begin
				if (take) begin
					best_q <= i_q[VA_W-1:0];
					bx_q   <= v_rd_q.x;
					by_q   <= v_rd_q.y;
				end
				top_q  <= take ? i_q[VA_W-1:0] : best_q;
				topy_q <= take ? v_rd_q.y : by_q;
			end
			ST_TOP_U: begin
				if (v_rd_q.x == bx_q) begin
					top_q  <= (top_q == '0) ? last_idx : top_q - 1'b1;
					topy_q <= v_rd_q.y;
				end
			end
			ST_UP_I: begin
				idx_q  <= top_q;
				curx_q <= bx_q;
				cury_q <= topy_q;
			end
			ST_UP_W:  idx_q <= (idx_q == '0) ? last_idx : idx_q - 1'b1;
			ST_UP_U: begin
				if ((v_rd_q.x > curx_q) && (ulen_q < count_q)) begin
					curx_q <= v_rd_q.x;
					cury_q <= v_rd_q.y;
				end else begin
					tbx_q  <= curx_q;
					tby_q  <= cury_q;
					idx_q  <= best_q;
					curx_q <= bx_q;
					cury_q <= by_q;
				end
			end
			ST_LOW_W: idx_q <= (idx_q == last_idx) ? '0 : idx_q + 1'b1;
			ST_LOW_U: begin
				if ((v_rd_q.x > curx_q) && (llen_q < count_q)) begin
					curx_q <= v_rd_q.x;
					cury_q <= v_rd_q.y;
				end else begin
					bby_q <= cury_q;
				end
			end
			ST_XF: begin
				case (step_q)
					3'd0: begin
						negx_q <= dx_q[32];
						negy_q <= dy_q[32];
						magx_q <= dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
						magy_q <= dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
					end
					3'd2: sx_q  <= scale_fin(prod_q, negx_q);
					3'd3: sy_q  <= scale_fin(prod_q, negy_q);
					3'd4: acc_q <= prod_q;
					3'd5: tx_q  <= sat_shr(acc_q + prod_q);
					3'd6: acc_q <= prod_q;
					3'd7: ty_q  <= sat_shr(acc_q - prod_q);
					default: ;
				endcase
			end
			ST_SA: begin
				if ((lo_q >= hi_q) && (curlen < CNT_W'(2))) begin
					da_q <= '0;
					db_q <= '0;
					dc_q <= '0;
					dd_q <= '0;
				end
			end
			ST_F3: begin
				lx_q <= v_rd_q.x;
				ly_q <= v_rd_q.y;
			end
			ST_F4: begin
				da_q <= {ty_q[31], ty_q} - {ly_q[31], ly_q};
				db_q <= {v_rd_q.x[31], v_rd_q.x} - {lx_q[31], lx_q};
				dc_q <= {tx_q[31], tx_q} - {lx_q[31], lx_q};
				dd_q <= {v_rd_q.y[31], v_rd_q.y} - {ly_q[31], ly_q};
			end
			ST_M2: p1_q <= prod_q;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ulen_q      <= '0;
			llen_q      <= '0;
			i_q         <= '0;
			steps_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			load_open_q <= 1'b0;
			ready_q     <= 1'b0;
			sel_q       <= 1'b0;
			step_q      <= '0;
			res_in_q    <= 1'b0;
			res_st_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (q_entry.kind == KIND_QUERY) begin
							if (!ready_q) begin
								res_in_q <= 1'b0;
								res_st_q <= 1'b1;
								state_q  <= ST_RES;
							end else begin
								step_q  <= '0;
								state_q <= ST_XF;
							end
						end else begin
							if (!load_open_q) begin
								ready_q <= 1'b0;
							end
							count_q     <= cnt_new;
							load_open_q <= (q_entry.kind != KIND_LAST);
							if ((q_entry.kind == KIND_LAST) && (cnt_new >= CNT_W'(3))) begin
								i_q     <= '0;
								state_q <= ST_FIND_R;
							end
						end
					end
				end
				ST_FIND_R: state_q <= ST_FIND_U;
				ST_FIND_U: begin
					if (i_q == count_q - 1'b1) begin
						steps_q <= '0;
						state_q <= ST_TOP_R;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_FIND_R;
					end
				end
				ST_TOP_R: state_q <= ST_TOP_U;
				ST_TOP_U: begin
					if ((v_rd_q.x == bx_q) && (steps_q + CNT_W'(2) < count_q)) begin
						steps_q <= steps_q + 1'b1;
						state_q <= ST_TOP_R;
					end else begin
						state_q <= ST_UP_I;
					end
				end
				ST_UP_I: begin
					ulen_q  <= '0;
					state_q <= ST_UP_W;
				end
				ST_UP_W: begin
					ulen_q  <= ulen_q + 1'b1;
					state_q <= ST_UP_U;
				end
				ST_UP_U: begin
					if ((v_rd_q.x > curx_q) && (ulen_q < count_q)) begin
						state_q <= ST_UP_W;
					end else begin
						llen_q  <= '0;
						state_q <= ST_LOW_W;
					end
				end
				ST_LOW_W: begin
					llen_q  <= llen_q + 1'b1;
					state_q <= ST_LOW_U;
				end
				ST_LOW_U: begin
					if ((v_rd_q.x > curx_q) && (llen_q < count_q)) begin
						state_q <= ST_LOW_W;
					end else begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_XF: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd7) begin
						state_q <= ST_CHK;
					end
				end
				// end columns and the x span are decided without a search
				ST_CHK: begin
					res_st_q <= 1'b0;
					if ((tx_q < bx_q) || (tx_q > tbx_q)) begin
						res_in_q <= 1'b0;
						state_q  <= ST_RES;
					end else if (tx_q == bx_q) begin
						res_in_q <= (ty_q <= topy_q) && (ty_q >= by_q);
						state_q  <= ST_RES;
					end else if (tx_q == tbx_q) begin
						res_in_q <= (ty_q <= tby_q) && (ty_q >= bby_q);
						state_q  <= ST_RES;
					end else begin
						sel_q   <= 1'b0;
						lo_q    <= '0;
						hi_q    <= ulen_q;
						state_q <= ST_SA;
					end
				end
				ST_SA: begin
					if (lo_q < hi_q) begin
						state_q <= ST_SB;
					end else if (curlen < CNT_W'(2)) begin
						state_q <= ST_M1;
					end else begin
						state_q <= ST_F1;
					end
				end
				ST_SB: state_q <= ST_SC;
				ST_SC: begin
					if ((tx_q < v_rd_q.x) || ((tx_q == v_rd_q.x) && (ty_q < v_rd_q.y))) begin
						hi_q <= mid;
					end else begin
						lo_q <= mid + 1'b1;
					end
					state_q <= ST_SA;
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: state_q <= ST_F4;
				ST_F4: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				// side of the edge: upper must not be above, lower not below
				ST_M3: begin
					if (!sel_q) begin
						if (p1_q > prod_q) begin
							res_in_q <= 1'b0;
							state_q  <= ST_RES;
						end else begin
							sel_q   <= 1'b1;
							lo_q    <= '0;
							hi_q    <= llen_q;
							state_q <= ST_SA;
						end
					end else begin
						res_in_q <= !(p1_q < prod_q);
						state_q  <= ST_RES;
					end
				end
				ST_RES: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if ((state_q == ST_RES) && out_free) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RES) && out_free) begin
			out_in_q <= res_in_q;
			out_st_q <= res_st_q;
		end
	end

	assign result.valid      = ov_q;
	assign result.inside_res = out_in_q;
	assign result.status     = out_st_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond store depth");

	a_chains_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (ulen_q != '0) && (llen_q != '0) && (ulen_q <= count_q) &&
		(llen_q <= count_q))
		else $error("ready polygon with bad chain lengths");

	a_search_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SC) |-> (lo_q < hi_q))
		else $error("search step on an empty interval");

	a_result_wait: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RES) && ov_q && !result.ready) |=> (state_q == ST_RES))
		else $error("result overwrote a pending result");
`endif

endmodule

FILE: src/point_in_convex_polygon.sv
// Top level of the convex polygon point tester: front end, queue and executor.
//
// Channels: item carries loads (opcode 0, one vertex each, counterclockwise,
// last_vertex on the final one) and queries (opcode 1). result carries one
// item per query: inside_res and status (1 when no polygon is loaded). cfg
// writes the transform registers by index; it is always ready.
// The executor stores each load vertex from its idle state. The closing
// vertex of a load of three or more then builds the chains: a leftmost
// search, a walk of the left column and the upper and lower chain walks.
// A query is decided without a search when the end columns or the x span
// decide it, and otherwise by a binary search of each chain in turn: each
// search step is a chain store read then a vertex store read on the single
// read ports, and all products share one 33 by 33 multiplier.
// A two-entry queue lets the front end keep accepting items while the
// executor works; a finished result waits in an output register, and the
// executor stalls in its result step while that register is full and ready is low.
// Reset clears the queue, the load state and the result register and sets
// the transform registers to identity; the vertex store is not cleared.
module point_in_convex_polygon import pic_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pic_in_if.sink    item,
	pic_out_if.source result,
	pic_cfg_if.sink   cfg
);

	logic       push_valid, push_ready, pop_valid, pop_ready;
	pic_entry_t push_entry, pop_entry;

	pic_front u_front (
		.item       (item),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	pic_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	pic_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (pop_valid),
		.q_entry (pop_entry),
		.q_ready (pop_ready),
		.result  (result)
	);

endmodule
